>>> hw/rtl/rcte_pkg.sv
`timescale 1ns / 1ps
// Package for the CSR trap emulator: beat types, command format, CSR table.
// No dependencies; every other file but rcte_ram imports it.
package rcte_pkg;

    localparam int CSR_COUNT_DEF = 40;
    localparam int IDX_W         = 6;
    localparam int VENDOR_W      = 48;
    localparam int CMDQ_DEPTH    = 4;
    localparam int CMDQ_PW       = $clog2(CMDQ_DEPTH);

    localparam logic [VENDOR_W-1:0] VENDOR_RESET = 48'h637365353336;
    localparam logic [6:0]  OP_SYSTEM    = 7'h73;
    localparam logic [31:0] INSTR_ECALL  = 32'h0000_0073;
    localparam logic [11:0] IMM_SRET     = 12'h102;
    localparam logic [11:0] IMM_MRET     = 12'h302;
    localparam logic [11:0] CODE_VENDOR  = 12'hf11;
    localparam logic [11:0] CODE_PMPCFG0 = 12'h3a0;
    localparam logic [11:0] CODE_PMPADR0 = 12'h3b0;

    // Positions of the CSRs that traps and returns touch directly, and of the vendor id.
    localparam logic [IDX_W-1:0] IDX_SSTATUS = 6'd8;
    localparam logic [IDX_W-1:0] IDX_STVEC   = 6'd12;
    localparam logic [IDX_W-1:0] IDX_SEPC    = 6'd15;
    localparam logic [IDX_W-1:0] IDX_SCAUSE  = 6'd16;
    localparam logic [IDX_W-1:0] IDX_VENDOR  = 6'd20;
    localparam logic [IDX_W-1:0] IDX_MSTATUS = 6'd24;
    localparam logic [IDX_W-1:0] IDX_MEDELEG = 6'd26;
    localparam logic [IDX_W-1:0] IDX_MTVEC   = 6'd29;
    localparam logic [IDX_W-1:0] IDX_MEPC    = 6'd32;
    localparam logic [IDX_W-1:0] IDX_MCAUSE  = 6'd33;

    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    typedef enum logic [2:0] {
        K_KILL, K_ECALL, K_SRET, K_MRET, K_CSR
    } t_kind;

    typedef enum logic [1:0] {
        CO_WRITE = 2'd1, CO_SET = 2'd2, CO_CLEAR = 2'd3
    } t_csr_op;

    typedef struct packed {
        logic        mode;
        logic [31:0] instruction;
        logic [63:0] pc;
        logic [63:0] rs1_value;
    } t_item;

    typedef struct packed {
        logic        killed;
        logic [63:0] next_pc;
        logic        rd_write;
        logic [4:0]  rd_index;
        logic [63:0] rd_value;
        logic [1:0]  privilege;
        logic        pmp_changed;
    } t_result;

    typedef struct packed {
        t_kind            kind;
        t_csr_op          op;
        logic             wr_en;
        logic             is_pmp;
        logic [1:0]       level;
        logic [IDX_W-1:0] idx;
        logic [4:0]       rd;
        logic [63:0]      operand;
        logic [63:0]      pc;
    } t_cmd;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_lookup;

    function automatic t_lookup csr_lookup(input logic [11:0] code);
        t_lookup r;
        r.hit = 1'b1;
        case (code)
            12'h000: r.idx = 6'd0;
            12'h004: r.idx = 6'd1;
            12'h005: r.idx = 6'd2;
            12'h040: r.idx = 6'd3;
            12'h041: r.idx = 6'd4;
            12'h042: r.idx = 6'd5;
            12'h043: r.idx = 6'd6;
            12'h044: r.idx = 6'd7;
            12'h100: r.idx = 6'd8;
            12'h102: r.idx = 6'd9;
            12'h103: r.idx = 6'd10;
            12'h104: r.idx = 6'd11;
            12'h105: r.idx = 6'd12;
            12'h106: r.idx = 6'd13;
            12'h140: r.idx = 6'd14;
            12'h141: r.idx = 6'd15;
            12'h142: r.idx = 6'd16;
            12'h143: r.idx = 6'd17;
            12'h144: r.idx = 6'd18;
            12'h180: r.idx = 6'd19;
            12'hf11: r.idx = 6'd20;
            12'hf12: r.idx = 6'd21;
            12'hf13: r.idx = 6'd22;
            12'hf14: r.idx = 6'd23;
            12'h300: r.idx = 6'd24;
            12'h301: r.idx = 6'd25;
            12'h302: r.idx = 6'd26;
            12'h303: r.idx = 6'd27;
            12'h304: r.idx = 6'd28;
            12'h305: r.idx = 6'd29;
            12'h306: r.idx = 6'd30;
            12'h340: r.idx = 6'd31;
            12'h341: r.idx = 6'd32;
            12'h342: r.idx = 6'd33;
            12'h343: r.idx = 6'd34;
            12'h344: r.idx = 6'd35;
            12'h34a: r.idx = 6'd36;
            12'h34b: r.idx = 6'd37;
            12'h3a0: r.idx = 6'd38;
            12'h3b0: r.idx = 6'd39;
            default: begin
                r.hit = 1'b0;
                r.idx = '0;
            end
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/rcte_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rcte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/rcte_front.sv
`timescale 1ns / 1ps
// Front end: decodes each trapped instruction into a command and queues it.
// Depends on rcte_pkg.
module rcte_front import rcte_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_cmd_valid,
    output t_cmd  o_cmd,
    input  logic  i_cmd_pop
);
    t_cmd    dec;
    t_lookup lk;
    logic [6:0]  op;
    logic [4:0]  rd, rs1;
    logic [2:0]  f3;
    logic [11:0] imm;

    assign op  = i_item.instruction[6:0];
    assign rd  = i_item.instruction[11:7];
    assign f3  = i_item.instruction[14:12];
    assign rs1 = i_item.instruction[19:15];
    assign imm = i_item.instruction[31:20];
    assign lk  = csr_lookup(imm);

    always_comb begin
        dec         = '0;
        dec.kind    = K_KILL;
        dec.op      = t_csr_op'(f3[1:0]);
        dec.idx     = lk.idx;
        dec.rd      = rd;
        dec.pc      = i_item.pc;
        dec.level   = (imm == CODE_VENDOR) ? PRIV_U : imm[9:8];
        // Only the register forms of set and clear skip the write when rs1 is x0.
        dec.wr_en   = !(!f3[2] && (f3[1:0] == CO_SET || f3[1:0] == CO_CLEAR) &&
                        rs1 == 5'd0);
        dec.is_pmp  = dec.wr_en && (imm == CODE_PMPCFG0 || imm == CODE_PMPADR0);
        if (f3[2]) begin
            dec.operand = {59'd0, rs1};
        end else if (rs1 == 5'd0) begin
            dec.operand = '0;
        end else begin
            dec.operand = i_item.rs1_value;
        end
        if (!i_item.mode) begin
            dec.kind = (i_item.instruction == INSTR_ECALL) ? K_ECALL : K_KILL;
        end else if (op != OP_SYSTEM) begin
            dec.kind = K_KILL;
        end else if (f3 == 3'd0) begin
            if (rd != 5'd0 || rs1 != 5'd0) begin
                dec.kind = K_KILL;
            end else if (imm == IMM_SRET) begin
                dec.kind = K_SRET;
            end else if (imm == IMM_MRET) begin
                dec.kind = K_MRET;
            end else begin
                dec.kind = K_KILL;
            end
        end else if (f3 == 3'd4 || !lk.hit) begin
            dec.kind = K_KILL;
        end else begin
            dec.kind = K_CSR;
        end
    end

    t_cmd                r_q [CMDQ_DEPTH];
    logic [CMDQ_PW-1:0]  r_wp, r_rp;
    logic [CMDQ_PW:0]    r_cnt;
    logic                push_ok, pop_ok;

    assign o_full      = (r_cnt == (CMDQ_PW+1)'(CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (CMDQ_PW+1)'(push_ok) - (CMDQ_PW+1)'(pop_ok);
        end
        if (push_ok) begin
            r_q[r_wp] <= dec;
        end
    end
endmodule

>>> hw/rtl/rcte_back.sv
`timescale 1ns / 1ps
// Back end: executes queued commands against the CSR file and privilege.
// Depends on rcte_pkg and rcte_ram.
module rcte_back import rcte_pkg::*; #(
    parameter int CSR_COUNT = CSR_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [VENDOR_W-1:0] i_vendor,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_out_pop,
    output logic                o_out_valid,
    output t_result             o_result
);
    localparam int IW = $clog2(CSR_COUNT);

    typedef enum logic {ST_IDLE, ST_EXEC} t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic                r_hit;
    logic [CSR_COUNT-1:0] r_vld;
    logic [VENDOR_W-1:0] r_vsnap;
    logic [1:0]          r_priv;
    logic [63:0] r_sstatus, r_stvec, r_sepc, r_scause, r_medeleg;
    logic [63:0] r_mstatus, r_mtvec, r_mepc, r_mcause;
    logic [63:0] n_sstatus, n_stvec, n_sepc, n_scause, n_medeleg;
    logic [63:0] n_mstatus, n_mtvec, n_mepc, n_mcause;
    logic [1:0]  n_priv;
    t_result     r_out, n_out;
    logic        r_out_valid;
    logic        take, kill, ram_we, spec;
    logic [63:0] rdata, old, nval;
    logic [IW-1:0] waddr;

    assign take      = (r_state == ST_IDLE) && i_cmd_valid && !r_out_valid;
    assign o_cmd_pop = take;
    assign waddr     = r_cmd.idx[IW-1:0];

    rcte_ram #(.WIDTH(64), .DEPTH(CSR_COUNT)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (nval),
        .i_re    (take),
        .i_raddr (i_cmd.idx[IW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        spec = 1'b1;
        case (r_cmd.idx)
            IDX_SSTATUS: old = r_sstatus;
            IDX_STVEC:   old = r_stvec;
            IDX_SEPC:    old = r_sepc;
            IDX_SCAUSE:  old = r_scause;
            IDX_MEDELEG: old = r_medeleg;
            IDX_MSTATUS: old = r_mstatus;
            IDX_MTVEC:   old = r_mtvec;
            IDX_MEPC:    old = r_mepc;
            IDX_MCAUSE:  old = r_mcause;
            default: begin
                spec = 1'b0;
                if (r_hit) begin
                    old = rdata;
                end else if (r_cmd.idx == IDX_VENDOR) begin
                    old = {16'd0, r_vsnap};
                end else begin
                    old = '0;
                end
            end
        endcase
        case (r_cmd.op)
            CO_SET:   nval = old | r_cmd.operand;
            CO_CLEAR: nval = old & ~r_cmd.operand;
            default:  nval = r_cmd.operand;
        endcase
    end

    always_comb begin
        n_sstatus = r_sstatus;  n_stvec = r_stvec;  n_sepc = r_sepc;
        n_scause  = r_scause;   n_medeleg = r_medeleg;
        n_mstatus = r_mstatus;  n_mtvec = r_mtvec;  n_mepc = r_mepc;
        n_mcause  = r_mcause;   n_priv = r_priv;
        n_out     = '0;
        kill      = 1'b0;
        ram_we    = 1'b0;
        case (r_cmd.kind)
            K_ECALL: begin
                if ((r_priv == PRIV_S && r_medeleg[1]) ||
                    (r_priv == PRIV_U && r_medeleg[3])) begin
                    n_sepc       = r_cmd.pc;
                    n_out.next_pc = r_stvec;
                    n_scause     = {60'd0, 2'b10, r_priv};
                    n_sstatus[1] = 1'b0;
                    n_sstatus[5] = r_sstatus[1];
                    n_sstatus[8] = r_priv[0];
                    n_priv       = PRIV_S;
                end else begin
                    n_mepc          = r_cmd.pc;
                    n_out.next_pc   = r_mtvec;
                    n_mcause        = {60'd0, 2'b10, r_priv};
                    n_mstatus[3]    = 1'b0;
                    n_mstatus[7]    = r_mstatus[3];
                    n_mstatus[12:11] = r_priv;
                    n_priv          = PRIV_M;
                end
            end
            K_SRET: begin
                if (r_priv != PRIV_S) begin
                    kill = 1'b1;
                end else begin
                    n_priv       = {1'b0, r_sstatus[8]};
                    n_sstatus[8] = 1'b0;
                    n_sstatus[5] = 1'b0;
                    n_sstatus[1] = r_sstatus[5];
                    n_out.next_pc = r_sepc;
                end
            end
            K_MRET: begin
                if (r_priv != PRIV_M) begin
                    kill = 1'b1;
                end else begin
                    n_priv           = r_mstatus[12:11];
                    n_mstatus[12:11] = 2'b00;
                    n_mstatus[7]     = 1'b0;
                    n_mstatus[3]     = r_mstatus[7];
                    n_out.next_pc    = r_mepc;
                end
            end
            K_CSR: begin
                if (r_priv < r_cmd.level) begin
                    kill = 1'b1;
                end else begin
                    n_out.next_pc     = r_cmd.pc + 64'd4;
                    n_out.pmp_changed = r_cmd.is_pmp;
                    if (r_cmd.rd != 5'd0) begin
                        n_out.rd_write = 1'b1;
                        n_out.rd_index = r_cmd.rd;
                        n_out.rd_value = old;
                    end
                    if (r_cmd.wr_en) begin
                        ram_we = !spec;
                        case (r_cmd.idx)
                            IDX_SSTATUS: n_sstatus = nval;
                            IDX_STVEC:   n_stvec   = nval;
                            IDX_SEPC:    n_sepc    = nval;
                            IDX_SCAUSE:  n_scause  = nval;
                            IDX_MEDELEG: n_medeleg = nval;
                            IDX_MSTATUS: n_mstatus = nval;
                            IDX_MTVEC:   n_mtvec   = nval;
                            IDX_MEPC:    n_mepc    = nval;
                            IDX_MCAUSE:  n_mcause  = nval;
                            default:     ram_we    = 1'b1;
                        endcase
                    end
                end
            end
            default: kill = 1'b1;
        endcase
        if (kill) begin
            n_out        = '0;
            n_out.killed = 1'b1;
            n_priv       = PRIV_M;
        end
        n_out.privilege = n_priv;
        if (r_state != ST_EXEC) begin
            ram_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_priv      <= PRIV_M;
            r_vld       <= '0;
            r_vsnap     <= VENDOR_RESET;
            r_sstatus <= '0; r_stvec <= '0; r_sepc <= '0; r_scause <= '0;
            r_medeleg <= '0; r_mstatus <= '0; r_mtvec <= '0; r_mepc <= '0;
            r_mcause  <= '0;
        end else begin
            if (i_out_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        r_cmd   <= i_cmd;
                        r_hit   <= r_vld[i_cmd.idx[IW-1:0]];
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    r_out       <= n_out;
                    r_out_valid <= 1'b1;
                    r_state     <= ST_IDLE;
                    if (kill) begin
                        r_priv  <= PRIV_M;
                        r_vld   <= '0;
                        r_vsnap <= i_vendor;
                        r_sstatus <= '0; r_stvec <= '0; r_sepc <= '0;
                        r_scause  <= '0; r_medeleg <= '0; r_mstatus <= '0;
                        r_mtvec   <= '0; r_mepc <= '0; r_mcause <= '0;
                    end else begin
                        r_priv    <= n_priv;
                        r_sstatus <= n_sstatus; r_stvec <= n_stvec;
                        r_sepc    <= n_sepc;    r_scause <= n_scause;
                        r_medeleg <= n_medeleg; r_mstatus <= n_mstatus;
                        r_mtvec   <= n_mtvec;   r_mepc <= n_mepc;
                        r_mcause  <= n_mcause;
                        if (ram_we) begin
                            r_vld[waddr] <= 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
endmodule

>>> hw/rtl/riscv_csr_trap_emulator.sv
`timescale 1ns / 1ps
// A pushed beat is queued, read from the RAM and executed into the result register. The
// back end works on one beat at a time: RAM read, execute, then the result pop frees the
// result register before the back end takes the next command.
// A 4-entry command queue lets the front keep taking beats while a result waits.
// Reset (synchronous, active low) empties both queues, sets machine privilege, zeroes
// every emulated CSR and reloads the vendor id; a kill does the same to guest state.
module riscv_csr_trap_emulator import rcte_pkg::*; #(
    parameter int CSR_COUNT = CSR_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_item               i_item,
    output logic                o_full,
    output logic                o_empty,
    input  logic                i_pop,
    output t_result             o_result,
    input  logic                i_cfg_we,
    input  logic [VENDOR_W-1:0] i_cfg_wdata
);
    // The vendor id register. It only takes effect at a kill; the CSR copy
    // seen by the guest is latched inside the back end at that moment.
    logic [VENDOR_W-1:0] r_vendor;
    logic                cmd_valid, cmd_pop, out_valid;
    t_cmd                cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vendor <= VENDOR_RESET;
        end else if (i_cfg_we) begin
            r_vendor <= i_cfg_wdata;
        end
    end

    // The front end decodes each beat right at the push and stores the
    // classified command, so the guest instruction fields are dropped early.
    rcte_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // The back end owns all guest state. It pulls a command only when its
    // result register is free, which keeps results strictly in order.
    rcte_back #(.CSR_COUNT(CSR_COUNT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vendor    (r_vendor),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_out_pop   (i_pop),
        .o_out_valid (out_valid),
        .o_result    (o_result)
    );

    assign o_empty = !out_valid;

    // A kill result carries nothing but the kill flag and machine privilege.
    a_kill_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.killed) |-> (o_result.next_pc == 64'd0 &&
            !o_result.rd_write && !o_result.pmp_changed))
        else $error("kill result carries stray fields");

    a_kill_priv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.killed) |-> (o_result.privilege == PRIV_M))
        else $error("kill result not in machine mode");

    a_no_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_result.rd_write) |->
            (o_result.rd_index == 5'd0 && o_result.rd_value == 64'd0))
        else $error("rd fields set without a register write");
endmodule

>>> test/tb_riscv_csr_trap_emulator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the CSR trap emulator: drives trapped instructions,
// predicts each result with its own model of the CSR file, and checks every beat.
// Depends on rcte_pkg and riscv_csr_trap_emulator only.
module tb_riscv_csr_trap_emulator;
    import rcte_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    // Function codes of the SYSTEM opcode, in the instruction's funct3 field.
    localparam logic [2:0] F3_PRIV  = 3'd0;
    localparam logic [2:0] F3_RW    = 3'd1;
    localparam logic [2:0] F3_RS    = 3'd2;
    localparam logic [2:0] F3_RC    = 3'd3;
    localparam logic [2:0] F3_BAD   = 3'd4;
    localparam logic [2:0] F3_RWI   = 3'd5;
    localparam logic [2:0] F3_RSI   = 3'd6;
    localparam logic [2:0] F3_RCI   = 3'd7;

    // CSR codes the predictor touches directly.
    localparam logic [11:0] C_SSTATUS = 12'h100;
    localparam logic [11:0] C_STVEC   = 12'h105;
    localparam logic [11:0] C_SEPC    = 12'h141;
    localparam logic [11:0] C_SCAUSE  = 12'h142;
    localparam logic [11:0] C_MSTATUS = 12'h300;
    localparam logic [11:0] C_MEDELEG = 12'h302;
    localparam logic [11:0] C_MTVEC   = 12'h305;
    localparam logic [11:0] C_MEPC    = 12'h341;
    localparam logic [11:0] C_MCAUSE  = 12'h342;

    localparam logic [11:0] CSR_CODES [40] = '{
        12'h000, 12'h004, 12'h005,
        12'h040, 12'h041, 12'h042, 12'h043, 12'h044,
        12'h100, 12'h102, 12'h103, 12'h104, 12'h105, 12'h106,
        12'h140, 12'h141, 12'h142, 12'h143, 12'h144,
        12'h180,
        12'hf11, 12'hf12, 12'hf13, 12'hf14,
        12'h300, 12'h301, 12'h302, 12'h303, 12'h304, 12'h305, 12'h306,
        12'h340, 12'h341, 12'h342, 12'h343, 12'h344, 12'h34a, 12'h34b,
        12'h3a0, 12'h3b0
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    t_item               item;
    logic                o_full;
    logic                o_empty;
    logic                pop;
    t_result             o_result;
    logic                cfg_we;
    logic [VENDOR_W-1:0] cfg_wdata;

    // Predictor state: the guest CSR file, its privilege and the vendor id register.
    logic [63:0]         guest_csr [40];
    logic [1:0]          guest_priv;
    logic [VENDOR_W-1:0] vendor_reg;

    t_result     pending_results [$];
    int          error_count;
    longint      cycle_count;
    bit          sender_idle_ok;
    bit          receiver_idle_ok;
    int          rx_stall;

    riscv_csr_trap_emulator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (item),
        .o_full      (o_full),
        .o_empty     (o_empty),
        .i_pop       (pop),
        .o_result    (o_result),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Predictor of the guest CSR file.
    // ---------------------------------------------------------------------

    function automatic int csr_slot(logic [11:0] code);
        for (int i = 0; i < 40; i++) begin
            if (CSR_CODES[i] == code) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Puts the guest back to its reset state: all zero, vendor id reloaded.
    function automatic void clear_guest();
        for (int i = 0; i < 40; i++) begin
            guest_csr[i] = 64'd0;
        end
        guest_csr[csr_slot(CODE_VENDOR)] = {16'd0, vendor_reg};
        guest_priv = PRIV_M;
    endfunction

    function automatic t_result killed_result();
        t_result r;
        clear_guest();
        r = '0;
        r.killed = 1'b1;
        r.privilege = PRIV_M;
        return r;
    endfunction

    // Works out the result of one trapped instruction and updates the guest state.
    function automatic t_result emulate_trap(t_item it);
        t_result     r;
        logic [31:0] ins;
        logic [4:0]  rd, rs1;
        logic [2:0]  f3;
        logic [11:0] imm;
        logic [1:0]  pv;
        logic [63:0] st, old;
        logic [1:0]  lvl;
        int          s, slot;
        bit          wrote;

        ins = it.instruction;
        rd  = ins[11:7];
        f3  = ins[14:12];
        rs1 = ins[19:15];
        imm = ins[31:20];
        pv  = guest_priv;
        r   = '0;

        if (it.mode == 1'b0) begin
            if (ins != INSTR_ECALL) begin
                return killed_result();
            end
            if ((pv == PRIV_S && guest_csr[csr_slot(C_MEDELEG)][1]) ||
                (pv == PRIV_U && guest_csr[csr_slot(C_MEDELEG)][3])) begin
                s  = csr_slot(C_SSTATUS);
                st = guest_csr[s];
                guest_csr[csr_slot(C_SEPC)] = it.pc;
                r.next_pc = guest_csr[csr_slot(C_STVEC)];
                guest_csr[csr_slot(C_SCAUSE)] = 64'(pv) + 64'd8;
                st[5] = st[1];
                st[1] = 1'b0;
                st[8] = pv[0];
                guest_csr[s] = st;
                guest_priv = PRIV_S;
            end else begin
                s  = csr_slot(C_MSTATUS);
                st = guest_csr[s];
                guest_csr[csr_slot(C_MEPC)] = it.pc;
                r.next_pc = guest_csr[csr_slot(C_MTVEC)];
                guest_csr[csr_slot(C_MCAUSE)] = 64'(pv) + 64'd8;
                st[7] = st[3];
                st[3] = 1'b0;
                st[12:11] = pv;
                guest_csr[s] = st;
                guest_priv = PRIV_M;
            end
            r.privilege = guest_priv;
            return r;
        end

        if (ins[6:0] != OP_SYSTEM || f3 == F3_BAD) begin
            return killed_result();
        end

        if (f3 == F3_PRIV) begin
            if (rd != 5'd0 || rs1 != 5'd0) begin
                return killed_result();
            end
            if (imm == IMM_SRET && pv == PRIV_S) begin
                s  = csr_slot(C_SSTATUS);
                st = guest_csr[s];
                guest_priv = {1'b0, st[8]};
                st[1] = st[5];
                st[5] = 1'b0;
                st[8] = 1'b0;
                guest_csr[s] = st;
                r.next_pc = guest_csr[csr_slot(C_SEPC)];
            end else if (imm == IMM_MRET && pv == PRIV_M) begin
                s  = csr_slot(C_MSTATUS);
                st = guest_csr[s];
                guest_priv = st[12:11];
                st[3] = st[7];
                st[7] = 1'b0;
                st[12:11] = 2'b00;
                guest_csr[s] = st;
                r.next_pc = guest_csr[csr_slot(C_MEPC)];
            end else begin
                return killed_result();
            end
            r.privilege = guest_priv;
            return r;
        end

        slot = csr_slot(imm);
        if (slot < 0) begin
            return killed_result();
        end
        lvl = (imm == CODE_VENDOR) ? 2'd0 : imm[9:8];
        if (pv < lvl) begin
            return killed_result();
        end
        old   = guest_csr[slot];
        wrote = 1'b1;
        case (f3)
            F3_RW: begin
                guest_csr[slot] = (rs1 == 5'd0) ? 64'd0 : it.rs1_value;
            end
            F3_RS: begin
                if (rs1 != 5'd0) guest_csr[slot] = old | it.rs1_value;
                else wrote = 1'b0;
            end
            F3_RC: begin
                if (rs1 != 5'd0) guest_csr[slot] = old & ~it.rs1_value;
                else wrote = 1'b0;
            end
            F3_RWI: guest_csr[slot] = 64'(rs1);
            F3_RSI: guest_csr[slot] = old | 64'(rs1);
            default: guest_csr[slot] = old & ~64'(rs1);
        endcase
        r.next_pc     = it.pc + 64'd4;
        r.rd_write    = (rd != 5'd0);
        r.rd_index    = rd;
        r.rd_value    = (rd != 5'd0) ? old : 64'd0;
        r.privilege   = guest_priv;
        r.pmp_changed = wrote && (imm == CODE_PMPCFG0 || imm == CODE_PMPADR0);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Driving and checking.
    // ---------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    task automatic idle_burst();
        repeat ($urandom_range(1, 10)) @(posedge i_clk);
    endtask

    // Sends one beat and records its predicted result once it is accepted.
    // Push stays high after the beat so the next call can follow back to back;
    // whoever lets time pass without a new beat drops it first.
    task automatic send_trap(t_item it);
        if (sender_idle_ok && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            idle_burst();
        end
        push <= 1'b1;
        item <= it;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        pending_results.push_back(emulate_trap(it));
    endtask

    // Pop side: random stalls, and a check of each accepted beat.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pop      <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (pop && !o_empty) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", 64'd0, 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.killed !== want.killed)
                        report_mismatch("killed", 64'(o_result.killed), 64'(want.killed));
                    if (o_result.next_pc !== want.next_pc)
                        report_mismatch("next_pc", o_result.next_pc, want.next_pc);
                    if (o_result.rd_write !== want.rd_write)
                        report_mismatch("rd_write", 64'(o_result.rd_write),
                                        64'(want.rd_write));
                    if (o_result.rd_index !== want.rd_index)
                        report_mismatch("rd_index", 64'(o_result.rd_index),
                                        64'(want.rd_index));
                    if (o_result.rd_value !== want.rd_value)
                        report_mismatch("rd_value", o_result.rd_value, want.rd_value);
                    if (o_result.privilege !== want.privilege)
                        report_mismatch("privilege", 64'(o_result.privilege),
                                        64'(want.privilege));
                    if (o_result.pmp_changed !== want.pmp_changed)
                        report_mismatch("pmp_changed", 64'(o_result.pmp_changed),
                                        64'(want.pmp_changed));
                end
            end
            // A stall holds pop low until the rx_stall counter has run down to zero.
            if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                pop      <= 1'b0;
            end else if (receiver_idle_ok && $urandom_range(0, 7) == 0) begin
                rx_stall <= $urandom_range(0, 9);
                pop      <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Waits until every predicted beat has arrived, then lets the pipe settle.
    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Writes the vendor id register while the block is idle.
    task automatic write_vendor(logic [VENDOR_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        vendor_reg = v;
    endtask

    function automatic logic [31:0] system_word(logic [11:0] imm, logic [4:0] rs1,
                                                logic [2:0] f3, logic [4:0] rd);
        return {imm, rs1, f3, rd, OP_SYSTEM};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_item csr_item(logic [11:0] imm, logic [4:0] rs1,
                                       logic [2:0] f3, logic [4:0] rd, logic [63:0] v);
        t_item it;
        it.mode        = 1'b1;
        it.instruction = system_word(imm, rs1, f3, rd);
        it.pc          = rand64();
        it.rs1_value   = v;
        return it;
    endfunction

    function automatic t_item ecall_item();
        t_item it;
        it.mode        = 1'b0;
        it.instruction = INSTR_ECALL;
        it.pc          = rand64();
        it.rs1_value   = rand64();
        return it;
    endfunction

    function automatic t_item return_item(logic [11:0] imm);
        return csr_item(imm, 5'd0, F3_PRIV, 5'd0, rand64());
    endfunction

    // ---------------------------------------------------------------------
    // Tests.
    // ---------------------------------------------------------------------

    // Edge cases: extreme fields, each CSR operation, traps, returns and kill paths.
    task automatic test_directed();
        t_item it;
        send_trap(csr_item(C_MTVEC, 5'd1, F3_RW, 5'd5, 64'hffff_ffff_ffff_ffff));
        send_trap(csr_item(C_STVEC, 5'd31, F3_RW, 5'd0, 64'h0));
        send_trap(csr_item(C_MEDELEG, 5'd10, F3_RS, 5'd31, 64'h000a));
        send_trap(csr_item(CODE_VENDOR, 5'd0, F3_RS, 5'd7, 64'h0));
        send_trap(csr_item(CODE_PMPCFG0, 5'd0, F3_RC, 5'd3, 64'hffff));
        send_trap(csr_item(CODE_PMPADR0, 5'd31, F3_RWI, 5'd4, 64'h0));
        send_trap(csr_item(CODE_PMPADR0, 5'd5, F3_RCI, 5'd4, 64'h0));
        send_trap(csr_item(C_MSTATUS, 5'd31, F3_RSI, 5'd1, 64'h0));
        send_trap(csr_item(C_MSTATUS, 5'd2, F3_RC, 5'd1, 64'h8000_0000_0000_0000));
        // MRET to S mode with MPP set to supervisor, then S-mode ECALL delegated.
        send_trap(csr_item(C_MSTATUS, 5'd3, F3_RW, 5'd0, 64'h0000_0000_0000_0888));
        send_trap(return_item(IMM_MRET));
        send_trap(ecall_item());
        send_trap(return_item(IMM_SRET));
        send_trap(csr_item(C_MSTATUS, 5'd0, F3_RS, 5'd2, 64'h0));
        send_trap(ecall_item());
        // MRET into privilege 2, where M CSRs and both returns kill; an ECALL and an SRET follow.
        send_trap(csr_item(C_MSTATUS, 5'd3, F3_RW, 5'd0, 64'h1000));
        send_trap(return_item(IMM_MRET));
        send_trap(ecall_item());
        send_trap(csr_item(C_MSTATUS, 5'd3, F3_RW, 5'd0, 64'h1000));
        send_trap(return_item(IMM_MRET));
        send_trap(return_item(IMM_SRET));
        send_trap(csr_item(12'h7c0, 5'd0, F3_RS, 5'd1, 64'h0));
        send_trap(csr_item(C_SEPC, 5'd0, F3_BAD, 5'd1, 64'h0));
        it = ecall_item();
        it.instruction = 32'hffff_ffff;
        send_trap(it);
        it = csr_item(C_SEPC, 5'd1, F3_RS, 5'd1, 64'h0);
        it.instruction[6:0] = 7'h33;
        send_trap(it);
        send_trap(csr_item(IMM_SRET, 5'd1, F3_PRIV, 5'd0, 64'h0));
        send_trap(csr_item(12'h105, 5'd0, F3_PRIV, 5'd0, 64'h0));
    endtask

    // Random well-formed programs: CSR traffic, traps and returns, plus some noise.
    task automatic test_random(int count);
        t_item it;
        int    pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                it = csr_item(CSR_CODES[$urandom_range(0, 39)], 5'($urandom),
                              3'($urandom_range(1, 3)) + (($urandom_range(0, 1)) ? 3'd4 : 3'd0),
                              5'($urandom), rand64());
                if ($urandom_range(0, 3) == 0) it.instruction[19:15] = 5'd0;
                if ($urandom_range(0, 3) == 0) it.instruction[11:7] = 5'd0;
                if ($urandom_range(0, 5) == 0) it.rs1_value = 64'h0a;
            end else if (pick < 70) begin
                it = ecall_item();
            end else if (pick < 82) begin
                it = return_item($urandom_range(0, 1) ? IMM_SRET : IMM_MRET);
            end else if (pick < 90) begin
                it = csr_item(C_MSTATUS, 5'd1, F3_RW, 5'd0,
                              {51'd0, 2'($urandom), 11'($urandom)});
            end else begin
                it.mode        = 1'($urandom);
                it.instruction = $urandom;
                it.pc          = rand64();
                it.rs1_value   = rand64();
            end
            send_trap(it);
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        error_count      = 0;
        cycle_count      = 0;
        sender_idle_ok   = 1'b1;
        receiver_idle_ok = 1'b1;
        vendor_reg = VENDOR_RESET;
        clear_guest();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        // A kill reloads the vendor id from whatever the register holds.
        write_vendor('0);
        clear_guest();
        send_trap(csr_item(C_MTVEC, 5'd0, F3_BAD, 5'd0, 64'h0));
        send_trap(csr_item(CODE_VENDOR, 5'd0, F3_RS, 5'd9, 64'h0));
        test_random(200);
        write_vendor('1);
        send_trap(ecall_item());
        test_random(200);
        write_vendor(48'($urandom) ^ {$urandom, 16'd0});
        test_random(100);
        // The tail runs at full rate with no stalls on either side.
        sender_idle_ok   = 1'b0;
        receiver_idle_ok = 1'b0;
        test_random(100);

        drain();
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/rcte_pkg.sv
hw/rtl/rcte_ram.sv
hw/rtl/rcte_front.sv
hw/rtl/rcte_back.sv
hw/rtl/riscv_csr_trap_emulator.sv
test/tb_riscv_csr_trap_emulator.sv
